// ----- hw/rtl/cpu_alu_with_flags_top_assert.svh -----
// Assertion macros for the cpu_alu_with_flags block.
// Used by the port checker; expects clk and rst in the scope of each use.
`ifndef CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define CAWF_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define CAWF_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cawf_pkg.sv -----
// Shared types and constants for the cpu_alu_with_flags pipeline.
// No dependencies; the decode, arith, flags and top files refer to it by scoped names.
`default_nettype none

package cawf_pkg;

  typedef enum logic [4:0] {
    OP_INC8       = 5'd0,
    OP_DEC8       = 5'd1,
    OP_INC16      = 5'd2,
    OP_DEC16      = 5'd3,
    OP_RLC        = 5'd4,
    OP_RL         = 5'd5,
    OP_RRC        = 5'd6,
    OP_RR         = 5'd7,
    OP_XOR        = 5'd8,
    OP_OR         = 5'd9,
    OP_AND16      = 5'd10,
    OP_CPL        = 5'd11,
    OP_ADD16      = 5'd12,
    OP_ADD8       = 5'd13,
    OP_ADC8       = 5'd14,
    OP_SUB8       = 5'd15,
    OP_SBC8       = 5'd16,
    OP_ADD_OFFSET = 5'd17,
    OP_BOOL16     = 5'd18
  } op_t;

  // Bit positions in the flag byte.
  localparam int FLAG_S = 7;
  localparam int FLAG_Z = 6;
  localparam int FLAG_V = 2;
  localparam int FLAG_C = 0;

  localparam int IN_W  = 48;

  // Decoded request: adder operands chosen per operation.
  typedef struct packed {
    op_t         op;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  f;
    logic [7:0]  y8;
    logic        c8;
    logic [15:0] y16;
    logic        c16;
  } dec_t;

  // Executed request: raw sums, logic result and carries.
  typedef struct packed {
    op_t         op;
    logic [15:0] a;
    logic [7:0]  f;
    logic [8:0]  sum8;
    logic        v8;
    logic [15:0] sum16;
    logic        c16;
    logic [15:0] lres;
    logic        lc;
  } ex_t;

  // Final result; flags sit above the result word as on the bus.
  typedef struct packed {
    logic [7:0]  flags;
    logic [15:0] result;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cawf_decode.sv -----
// Stage one: captures a request and selects the adder operands per operation.
// Depends on cawf_pkg.
`default_nettype none

module cawf_decode (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [cawf_pkg::IN_W-1:0] in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output cawf_pkg::dec_t                 out_data
);

  cawf_pkg::dec_t d_next;
  logic           valid;

  always_comb begin
    d_next     = '0;
    d_next.op  = cawf_pkg::op_t'(in_data[4:0]);
    d_next.a   = in_data[20:5];
    d_next.b   = in_data[36:21];
    d_next.f   = in_data[44:37];
    case (d_next.op)
      cawf_pkg::OP_INC8: begin
        d_next.c8 = 1'b1;
      end
      cawf_pkg::OP_DEC8: begin
        d_next.y8 = 8'hff;
      end
      cawf_pkg::OP_ADD8: begin
        d_next.y8 = d_next.b[7:0];
      end
      cawf_pkg::OP_ADC8: begin
        d_next.y8 = d_next.b[7:0];
        d_next.c8 = d_next.f[cawf_pkg::FLAG_C];
      end
      cawf_pkg::OP_SUB8: begin
        d_next.y8 = ~d_next.b[7:0];
        d_next.c8 = 1'b1;
      end
      cawf_pkg::OP_SBC8: begin
        // a - b - c is a + ~b + !c; carry out means no borrow.
        d_next.y8 = ~d_next.b[7:0];
        d_next.c8 = ~d_next.f[cawf_pkg::FLAG_C];
      end
      cawf_pkg::OP_INC16: begin
        d_next.c16 = 1'b1;
      end
      cawf_pkg::OP_DEC16: begin
        d_next.y16 = 16'hffff;
      end
      cawf_pkg::OP_ADD16: begin
        d_next.y16 = d_next.b;
      end
      cawf_pkg::OP_ADD_OFFSET: begin
        d_next.y16 = {{8{d_next.b[7]}}, d_next.b[7:0]};
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cawf_arith.sv -----
// Stage two: 8-bit and 16-bit adders, rotates and bitwise logic.
// Depends on cawf_pkg.
`default_nettype none

module cawf_arith (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire cawf_pkg::dec_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cawf_pkg::ex_t  out_data
);

  cawf_pkg::ex_t e_next;
  logic [16:0]   sum16;
  logic          cin;
  logic          valid;

  always_comb begin
    cin         = in_data.f[cawf_pkg::FLAG_C];
    e_next      = '0;
    e_next.op   = in_data.op;
    e_next.a    = in_data.a;
    e_next.f    = in_data.f;
    e_next.sum8 = {1'b0, in_data.a[7:0]} + {1'b0, in_data.y8} + {8'h00, in_data.c8};
    // Signed overflow: both addends share a sign that the sum does not.
    e_next.v8   = (in_data.a[7] == in_data.y8[7]) && (e_next.sum8[7] != in_data.a[7]);
    sum16       = {1'b0, in_data.a} + {1'b0, in_data.y16} + {16'h0000, in_data.c16};
    e_next.sum16 = sum16[15:0];
    // With a negative offset the sum is out of range exactly when no carry occurs.
    e_next.c16  = sum16[16] ^ ((in_data.op == cawf_pkg::OP_ADD_OFFSET) && in_data.b[7]);
    e_next.lc   = ((in_data.op == cawf_pkg::OP_RLC) || (in_data.op == cawf_pkg::OP_RL)) ?
                  in_data.a[7] : in_data.a[0];
    case (in_data.op)
      cawf_pkg::OP_RLC:    e_next.lres = {8'h00, in_data.a[6:0], in_data.a[7]};
      cawf_pkg::OP_RL:     e_next.lres = {8'h00, in_data.a[6:0], cin};
      cawf_pkg::OP_RRC:    e_next.lres = {8'h00, in_data.a[0], in_data.a[7:1]};
      cawf_pkg::OP_RR:     e_next.lres = {8'h00, cin, in_data.a[7:1]};
      cawf_pkg::OP_XOR:    e_next.lres = {8'h00, in_data.a[7:0] ^ in_data.b[7:0]};
      cawf_pkg::OP_OR:     e_next.lres = {8'h00, in_data.a[7:0] | in_data.b[7:0]};
      cawf_pkg::OP_AND16:  e_next.lres = in_data.a & in_data.b;
      cawf_pkg::OP_CPL:    e_next.lres = {8'h00, ~in_data.a[7:0]};
      cawf_pkg::OP_BOOL16: e_next.lres = {15'h0000, |in_data.a};
      default:             e_next.lres = in_data.a;
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= e_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cawf_flags.sv -----
// Stage three: picks the result word and builds the new flag byte.
// Depends on cawf_pkg; its register is the block's output register.
`default_nettype none

module cawf_flags (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire cawf_pkg::ex_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cawf_pkg::res_t out_data
);

  cawf_pkg::res_t r_next;
  logic [7:0]     r8;
  logic           valid;

  always_comb begin
    r_next.result = in_data.a;
    r_next.flags  = in_data.f;
    r8            = in_data.sum8[7:0];
    case (in_data.op)
      cawf_pkg::OP_INC8, cawf_pkg::OP_DEC8, cawf_pkg::OP_ADD8, cawf_pkg::OP_ADC8,
      cawf_pkg::OP_SUB8, cawf_pkg::OP_SBC8: begin
        r_next.result                = {8'h00, r8};
        r_next.flags[cawf_pkg::FLAG_S] = r8[7];
        r_next.flags[cawf_pkg::FLAG_Z] = (r8 == 8'h00);
        r_next.flags[cawf_pkg::FLAG_V] = in_data.v8;
        if ((in_data.op == cawf_pkg::OP_ADD8) || (in_data.op == cawf_pkg::OP_ADC8)) begin
          r_next.flags[cawf_pkg::FLAG_C] = in_data.sum8[8];
        end else if ((in_data.op == cawf_pkg::OP_SUB8) ||
                     (in_data.op == cawf_pkg::OP_SBC8)) begin
          r_next.flags[cawf_pkg::FLAG_C] = ~in_data.sum8[8];
        end
      end
      cawf_pkg::OP_INC16, cawf_pkg::OP_DEC16: begin
        r_next.result = in_data.sum16;
      end
      cawf_pkg::OP_ADD16, cawf_pkg::OP_ADD_OFFSET: begin
        r_next.result                = in_data.sum16;
        r_next.flags[cawf_pkg::FLAG_C] = in_data.c16;
      end
      cawf_pkg::OP_RLC, cawf_pkg::OP_RL, cawf_pkg::OP_RRC, cawf_pkg::OP_RR: begin
        r_next.result                = in_data.lres;
        r_next.flags[cawf_pkg::FLAG_C] = in_data.lc;
      end
      cawf_pkg::OP_XOR, cawf_pkg::OP_OR: begin
        r_next.result                = in_data.lres;
        r_next.flags[cawf_pkg::FLAG_S] = in_data.lres[7];
        r_next.flags[cawf_pkg::FLAG_Z] = (in_data.lres[7:0] == 8'h00);
        r_next.flags[cawf_pkg::FLAG_V] = |in_data.lres[7:4];
        r_next.flags[cawf_pkg::FLAG_C] = 1'b0;
      end
      cawf_pkg::OP_AND16: begin
        r_next.result                = in_data.lres;
        r_next.flags[cawf_pkg::FLAG_S] = in_data.lres[15];
        r_next.flags[cawf_pkg::FLAG_Z] = (in_data.lres == 16'h0000);
        r_next.flags[cawf_pkg::FLAG_V] = 1'b0;
        r_next.flags[cawf_pkg::FLAG_C] = 1'b0;
      end
      cawf_pkg::OP_CPL: begin
        r_next.result = in_data.lres;
      end
      cawf_pkg::OP_BOOL16: begin
        r_next.result                = in_data.lres;
        r_next.flags[cawf_pkg::FLAG_S] = 1'b0;
        r_next.flags[cawf_pkg::FLAG_Z] = ~in_data.lres[0];
        r_next.flags[cawf_pkg::FLAG_V] = 1'b0;
        r_next.flags[cawf_pkg::FLAG_C] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= r_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cpu_alu_with_flags_top.sv -----
// 8/16-bit CPU ALU with flags, built as a three-stage pipeline. A request
// carries an operation code, two 16-bit operands and the current flag byte
// (S bit 7, Z bit 6, L/V bit 2, C bit 0); each request yields exactly one
// result: a 16-bit word and the updated flag byte, with flag bits that the
// operation does not touch passed through. Unused operation codes return
// operand_a and the incoming flags unchanged. The block takes one request
// per clock while the output is not stalled. A request accepted at a clock
// edge passes its three register stages in order (operand decode, the 8-bit
// and 16-bit adders with the logic unit, and the result and flag select that
// ends in the output register) before its result shows on the master side.
// The result stays on the master side until taken; tready back-pressure
// stalls each stage only when it is full, so bubbles fill up while the
// consumer waits. s_tready depends on m_tready through the stage ready
// chain. There is no state between requests, and reset only clears the
// valid bits of the stages.
// Depends on cawf_pkg, cawf_decode, cawf_arith and cawf_flags.
`default_nettype none

module cpu_alu_with_flags_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // op [4:0], operand_a [20:5], operand_b [36:21], flags_in [44:37], zeros above
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result [15:0], flags_out [23:16]
  output logic [23:0]      m_tdata
);

  cawf_pkg::dec_t dec_data;
  cawf_pkg::ex_t  ex_data;
  cawf_pkg::res_t res_data;
  logic           dec_valid;
  logic           dec_ready;
  logic           ex_valid;
  logic           ex_ready;

  // Stage one: request register and operand select.
  cawf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // Stage two: adders and logic unit.
  cawf_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (ex_valid),
    .out_ready (ex_ready),
    .out_data  (ex_data)
  );

  // Stage three: result select and flag byte, registered at the output.
  cawf_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ex_valid),
    .in_ready  (ex_ready),
    .in_data   (ex_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_data)
  );

  assign m_tdata = res_data;

endmodule

`default_nettype wire

// ----- hw/rtl/cawf_checker.sv -----
// Port-level checker for cpu_alu_with_flags_top, attached by bind.
// Depends on the assertion macros in cpu_alu_with_flags_top_assert.svh.
`default_nettype none

`include "cpu_alu_with_flags_top_assert.svh"

module cawf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // A stalled result keeps its value until it is taken.
  `CAWF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // With the output draining, every stage can move, so the input is open.
  `CAWF_ASSERT_NOW(a_ready_path, m_tready, s_tready, "input blocked while output is ready")

  // A request accepted into a draining pipe reaches the output after passing the decode, arith and flags registers.
  `CAWF_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready, m_tvalid, "request lost in pipeline")

  // No result comes out right after reset.
  `CAWF_ASSERT_NOW(a_reset_empty, $fell(rst), !m_tvalid, "result valid after reset")

endmodule

bind cpu_alu_with_flags_top cawf_checker u_cawf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
